>>> src/cnms_pkg.sv
package cnms_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAG_BITS   = 16;
  localparam int ANGLE_BITS = 16;
  localparam int CFG_BITS   = 11;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  // half of a 45-degree sector: 1/16 turn
  localparam logic [ANGLE_BITS-1:0] HALF_SECTOR = ANGLE_BITS'(1) << (ANGLE_BITS - 4);

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    AXIS_EW   = 2'd0,
    AXIS_DIAG = 2'd1,
    AXIS_NS   = 2'd2,
    AXIS_ANTI = 2'd3
  } axis_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]   mag;
    logic [ANGLE_BITS-1:0] ang;
  } pix_t;

  typedef struct packed {
    pix_t up;
    pix_t mid;
  } line_t;

  typedef struct packed {
    pix_t up;
    pix_t mid;
    pix_t cur;
    logic emit;
    logic row_end;
    logic frame_end;
  } job_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]          in_magnitude;
    logic signed [ANGLE_BITS-1:0] in_angle;
  } in_item_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]          out_magnitude;
    logic signed [ANGLE_BITS-1:0] out_angle;
    logic                         row_end;
    logic                         frame_end;
  } out_item_t;

  // last column index for a padded row length, clamped to [3, MAX_WIDTH]
  function automatic logic [COL_BITS-1:0] width_last(input logic [CFG_BITS-1:0] v);
    logic [CFG_BITS-1:0] t;
    if (v < CFG_BITS'(3)) begin
      t = CFG_BITS'(3);
    end else if (v > CFG_BITS'(MAX_WIDTH)) begin
      t = CFG_BITS'(MAX_WIDTH);
    end else begin
      t = v;
    end
    t = t - CFG_BITS'(1);
    return t[COL_BITS-1:0];
  endfunction

  function automatic logic [ROW_BITS-1:0] height_last(input logic [CFG_BITS-1:0] v);
    logic [CFG_BITS-1:0] t;
    if (v < CFG_BITS'(3)) begin
      t = CFG_BITS'(3);
    end else if (v > CFG_BITS'(MAX_HEIGHT)) begin
      t = CFG_BITS'(MAX_HEIGHT);
    end else begin
      t = v;
    end
    t = t - CFG_BITS'(1);
    return t[ROW_BITS-1:0];
  endfunction

endpackage

>>> src/cnms_front.sv
module cnms_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  cnms_pkg::in_item_t           in_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_addr,
  input  logic [cnms_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic [cnms_pkg::Q_AW:0]      q_level,
  output logic                         q_push,
  output cnms_pkg::job_t               q_data
);

  logic [cnms_pkg::COL_BITS-1:0] col_r, col_nxt;
  logic [cnms_pkg::ROW_BITS-1:0] row_r, row_nxt;
  logic [cnms_pkg::COL_BITS-1:0] wlast_r, wlast_nxt;
  logic [cnms_pkg::ROW_BITS-1:0] hlast_r, hlast_nxt;

  logic                          s1_v_r;
  logic [cnms_pkg::COL_BITS-1:0] s1_addr_r;
  cnms_pkg::pix_t                s1_cur_r;
  logic                          s1_emit_r;
  logic                          s1_row_end_r;
  logic                          s1_frame_end_r;
  cnms_pkg::line_t               rd_r;

  cnms_pkg::line_t line_mem [cnms_pkg::MAX_WIDTH];

  logic accept;
  logic cfg_hit;
  logic at_wlast;

  // in-flight stage-1 item counts against the queue room
  assign in_full = (q_level + {{cnms_pkg::Q_AW{1'b0}}, s1_v_r})
                   > (cnms_pkg::Q_AW+1)'(cnms_pkg::Q_DEPTH - 1);
  assign accept  = in_push && !in_full;
  assign cfg_hit = cfg_we && (cfg_addr == cnms_pkg::REG_SRC_WIDTH ||
                              cfg_addr == cnms_pkg::REG_SRC_HEIGHT);
  assign at_wlast = (col_r == wlast_r);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_we && cfg_addr == cnms_pkg::REG_SRC_WIDTH) begin
      wlast_nxt = cnms_pkg::width_last(cfg_wdata);
    end
    if (cfg_we && cfg_addr == cnms_pkg::REG_SRC_HEIGHT) begin
      hlast_nxt = cnms_pkg::height_last(cfg_wdata);
    end
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (at_wlast) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast_r) ? '0 : row_r + cnms_pkg::ROW_BITS'(1);
      end else begin
        col_nxt = col_r + cnms_pkg::COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      wlast_r <= cnms_pkg::COL_BITS'(cnms_pkg::MAX_WIDTH - 1);
      hlast_r <= cnms_pkg::ROW_BITS'(cnms_pkg::MAX_HEIGHT - 1);
      s1_v_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
      s1_v_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r      <= col_r;
      s1_cur_r       <= '{mag: in_data.in_magnitude, ang: in_data.in_angle};
      s1_emit_r      <= (row_r >= cnms_pkg::ROW_BITS'(2)) && (col_r >= cnms_pkg::COL_BITS'(2));
      s1_row_end_r   <= at_wlast;
      s1_frame_end_r <= at_wlast && (row_r == hlast_r);
    end
  end

  // line store: rows r-2 and r-1 per column; same-address reuse is a full row apart
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_mem[s1_addr_r] <= '{up: rd_r.mid, mid: s1_cur_r};
    end
  end

  assign q_push = s1_v_r;
  assign q_data = '{up: rd_r.up, mid: rd_r.mid, cur: s1_cur_r, emit: s1_emit_r,
                    row_end: s1_row_end_r, frame_end: s1_frame_end_r};

endmodule

>>> src/cnms_queue.sv
module cnms_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  cnms_pkg::job_t          push_data,
  input  logic                    pop,
  output logic                    valid,
  output cnms_pkg::job_t          head,
  output logic [cnms_pkg::Q_AW:0] level
);

  cnms_pkg::job_t              slot_r [cnms_pkg::Q_DEPTH];
  logic [cnms_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [cnms_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [cnms_pkg::Q_AW:0]     cnt_r;
  logic                        do_pop;

  assign valid  = (cnt_r != '0);
  assign head   = slot_r[rd_ptr_r];
  assign level  = cnt_r;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + cnms_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + cnms_pkg::Q_AW'(1);
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + (cnms_pkg::Q_AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (cnms_pkg::Q_AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/cnms_back.sv
module cnms_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cnms_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output cnms_pkg::out_item_t out_data
);

  // window: [0..2] column c-2 top..bottom, [3..5] column c-1
  cnms_pkg::pix_t win_r [6];

  cnms_pkg::out_item_t ob_r [2];
  logic                ob_wr_r;
  logic                ob_rd_r;
  logic [1:0]          ob_cnt_r;

  logic [cnms_pkg::ANGLE_BITS-1:0] ang_rot;
  cnms_pkg::axis_t                 axis;
  logic [cnms_pkg::MAG_BITS-1:0]   m;
  logic                            keep;
  logic                            ob_space;
  logic                            ob_push;
  logic                            ob_pop;
  cnms_pkg::out_item_t             res;

  assign m       = win_r[4].mag;
  assign ang_rot = win_r[4].ang + cnms_pkg::HALF_SECTOR;
  assign axis    = cnms_pkg::axis_t'(ang_rot[cnms_pkg::ANGLE_BITS-2 -: 2]);

  always_comb begin
    unique case (axis)
      cnms_pkg::AXIS_EW:   keep = (m > win_r[1].mag) && (m > q_head.mid.mag);
      cnms_pkg::AXIS_DIAG: keep = (m > win_r[0].mag) && (m > q_head.cur.mag);
      cnms_pkg::AXIS_NS:   keep = (m > win_r[3].mag) && (m > win_r[5].mag);
      cnms_pkg::AXIS_ANTI: keep = (m > win_r[2].mag) && (m > q_head.up.mag);
      default:             keep = 1'b0;
    endcase
  end

  assign res = '{out_magnitude: keep ? m : '0, out_angle: win_r[4].ang,
                 row_end: q_head.row_end, frame_end: q_head.frame_end};

  assign ob_pop   = out_pop && !out_empty;
  assign ob_space = (ob_cnt_r != 2'd2) || ob_pop;
  // non-emitting items only shift the window and never wait on the output
  assign q_pop    = q_valid && (!q_head.emit || ob_space);
  assign ob_push  = q_pop && q_head.emit;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= q_head.up;
      win_r[4] <= q_head.mid;
      win_r[5] <= q_head.cur;
    end
    if (ob_push) begin
      ob_r[ob_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (ob_push) begin
        ob_wr_r <= !ob_wr_r;
      end
      if (ob_pop) begin
        ob_rd_r <= !ob_rd_r;
      end
      case ({ob_push, ob_pop})
        2'b10:   ob_cnt_r <= ob_cnt_r + 2'd1;
        2'b01:   ob_cnt_r <= ob_cnt_r - 2'd1;
        default: ob_cnt_r <= ob_cnt_r;
      endcase
    end
  end

  assign out_empty = (ob_cnt_r == 2'd0);
  assign out_data  = ob_r[ob_rd_r];

endmodule

>>> src/canny_non_max_suppression.sv
// Path: the pixel right-below a result's centre passes the stage-1 registers, the queue and
// the output buffer before the result can be popped. Throughput: one pixel per cycle while
// in_full is low, set by the line store (one read port and one write port, one read and
// one write per pixel) and the one-pixel-per-cycle window shift.
// Reset (synchronous, rst_n low): counts, queue and output buffer emptied, size registers
// back to 1024 x 1024; line stores are not cleared and are refilled by each frame.
module canny_non_max_suppression (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  cnms_pkg::in_item_t            in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output cnms_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [cnms_pkg::CFG_BITS-1:0] cfg_wdata
);

  logic                    q_push;
  cnms_pkg::job_t          q_wdata;
  logic                    q_pop;
  logic                    q_valid;
  cnms_pkg::job_t          q_head;
  logic [cnms_pkg::Q_AW:0] q_level;

  cnms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_level   (q_level),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  cnms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .level     (q_level)
  );

  cnms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> src/cnms_checker.sv
module cnms_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input cnms_pkg::out_item_t out_data
);

  // the frame ends on the last pixel of a row
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (!out_data.frame_end || out_data.row_end))
    else $error("frame_end without row_end");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_room_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_full)
    else $error("input full after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind canny_non_max_suppression cnms_checker u_cnms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

>>> tb/sv/canny_non_max_suppression_check.sv
module canny_non_max_suppression_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  cnms_pkg::in_item_t            in_data,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  cnms_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [cnms_pkg::CFG_BITS-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending_count
);
  import cnms_pkg::*;

  // line_above holds source row r-2, line_prev row r-1, indexed by column
  pix_t line_above [MAX_WIDTH];
  pix_t line_prev [MAX_WIDTH];
  // win[0..2]: column c-2 top..bottom, win[3..5]: column c-1 top..bottom
  pix_t win [6];
  logic [CFG_BITS-1:0] src_width_q;
  logic [CFG_BITS-1:0] src_height_q;
  int unsigned col;
  int unsigned row;
  out_item_t thinned_q [$];
  int faults;
  int unsigned result_idx;

  function automatic int unsigned span(input logic [CFG_BITS-1:0] v, input int unsigned top);
    if (v < 3) return 3;
    if (v > top) return top;
    return v;
  endfunction

  task automatic thin_pixel(input in_item_t px);
    pix_t cur;
    pix_t up;
    pix_t mid;
    pix_t ctr;
    int unsigned w;
    int unsigned h;
    logic keep;
    logic [ANGLE_BITS-1:0] rot;
    out_item_t res;
    w = span(src_width_q, MAX_WIDTH);
    h = span(src_height_q, MAX_HEIGHT);
    cur.mag = px.in_magnitude;
    cur.ang = px.in_angle;
    up = line_above[col];
    mid = line_prev[col];
    if (row >= 2 && col >= 2) begin
      ctr = win[4];
      // shift by half a sector so each boundary falls into the sector above it
      rot = ctr.ang + HALF_SECTOR;
      case (axis_t'(rot[ANGLE_BITS-2 -: 2]))
        AXIS_EW:   keep = ctr.mag > win[1].mag && ctr.mag > mid.mag;
        AXIS_DIAG: keep = ctr.mag > win[0].mag && ctr.mag > cur.mag;
        AXIS_NS:   keep = ctr.mag > win[3].mag && ctr.mag > win[5].mag;
        default:   keep = ctr.mag > win[2].mag && ctr.mag > up.mag;
      endcase
      res.out_magnitude = keep ? ctr.mag : '0;
      res.out_angle = ctr.ang;
      res.row_end = (col == w - 1);
      res.frame_end = (col == w - 1) && (row == h - 1);
      thinned_q.push_back(res);
    end
    line_above[col] = mid;
    line_prev[col] = cur;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = cur;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    result_idx++;
    if (thinned_q.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("result %0d: unexpected transaction mag %h ang %h row_end %b frame_end %b",
                 result_idx, got.out_magnitude, got.out_angle, got.row_end, got.frame_end);
      return;
    end
    want = thinned_q.pop_front();
    if (got.out_magnitude !== want.out_magnitude || got.out_angle !== want.out_angle ||
        got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
      faults++;
      if (faults <= 10) begin
        $write("result %0d: expected mag %h ang %h row_end %b frame_end %b, ",
               result_idx, want.out_magnitude, want.out_angle, want.row_end, want.frame_end);
        $display("got mag %h ang %h row_end %b frame_end %b",
                 got.out_magnitude, got.out_angle, got.row_end, got.frame_end);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thinned_q.delete();
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      faults = 0;
      result_idx = 0;
      src_width_q = CFG_BITS'(MAX_WIDTH);
      src_height_q = CFG_BITS'(MAX_HEIGHT);
    end else begin
      if (cfg_we) begin
        // a write to an unused index leaves the frame position alone
        if (cfg_addr == REG_SRC_WIDTH) begin
          src_width_q = cfg_wdata;
          col = 0;
          row = 0;
        end else if (cfg_addr == REG_SRC_HEIGHT) begin
          src_height_q = cfg_wdata;
          col = 0;
          row = 0;
        end
      end
      if (in_push && !in_full) thin_pixel(in_data);
      if (out_pop && !out_empty) check_result(out_data);
    end
    pending_count <= thinned_q.size();
    fail_count <= faults;
  end

endmodule

>>> tb/sv/canny_non_max_suppression_test.sv
module canny_non_max_suppression_test;
  import cnms_pkg::*;

  localparam logic [1:0] REG_RESERVED0 = 2'd2;
  localparam logic [1:0] REG_RESERVED1 = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  in_item_t            in_data = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_addr = REG_SRC_WIDTH;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  int fail_count;
  int pending_count;
  int burst_left = 0;
  int stall_cycles = 0;
  logic [15:0] pop_pattern;
  int pop_phase;

  always #6 clk = ~clk;

  canny_non_max_suppression i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  canny_non_max_suppression_check i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // receiver: rotating stall pattern, reloaded each time pop_phase wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      pop_pattern <= 16'hA5C3;
      pop_phase <= 0;
      out_pop <= 1'b0;
    end else begin
      if (pop_phase == 63) begin
        case ($urandom_range(0, 3))
          0: pop_pattern <= 16'hFFFF;
          1: pop_pattern <= 16'($urandom() & $urandom()) | 16'h0001;
          default: pop_pattern <= 16'($urandom()) | 16'h0101;
        endcase
        pop_phase <= 0;
      end else begin
        pop_pattern <= {pop_pattern[14:0], pop_pattern[15]};
        pop_phase <= pop_phase + 1;
      end
      out_pop <= pop_pattern[15];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t rand_pixel();
    in_item_t p;
    case ($urandom_range(0, 7))
      0: p.in_magnitude = '0;
      1: p.in_magnitude = '1;
      2, 3: p.in_magnitude = 16'($urandom_range(0, 3));  // ties are common
      default: p.in_magnitude = 16'($urandom());
    endcase
    if ($urandom_range(0, 3) == 0)
      p.in_angle = 16'($urandom_range(0, 7) * 32'h2000 + 32'h1000 - $urandom_range(0, 1));
    else
      p.in_angle = 16'($urandom());
    return p;
  endfunction

  task automatic send(input in_item_t px);
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_push <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_BITS'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop push, let the count of expected results catch up with the last transaction,
  // drain every expected result, then let the pipeline empty
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic frame_phase(input int unsigned w, input int unsigned h, input int unsigned n);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    repeat (n) send(rand_pixel());
    settle();
  endtask

  initial begin
    in_item_t px;
    int unsigned random_sent;
    int unsigned n;
    int unsigned pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 5x5 frame: angles on both sides of every sector boundary, magnitude extremes,
    // equal neighbors on the anti-diagonal
    write_reg(REG_SRC_WIDTH, 5);
    write_reg(REG_SRC_HEIGHT, 5);
    for (int i = 0; i < 25; i++) begin
      case (i % 4)
        0: px.in_magnitude = 16'hFFFF;
        1: px.in_magnitude = 16'h0000;
        2: px.in_magnitude = 16'h5A5A;
        default: px.in_magnitude = 16'hA5A5;
      endcase
      px.in_angle = 16'((i % 8) * 32'h2000 + 32'h1000 - ((i / 8) & 1));
      send(px);
    end
    settle();

    // out-of-range sizes clamp; back-to-back 3x3 frames and rows of three in a 1024-row frame
    frame_phase(0, 2, 27);
    frame_phase(1, 1024, 24);
    frame_phase(2, 2047, 24);
    frame_phase(3, 3, 18);

    random_sent = 0;
    pick = 2;
    while (random_sent < 200) begin
      case (pick)
        0: write_reg(REG_SRC_WIDTH, ($urandom_range(0, 9) == 0) ?
                     $urandom_range(0, 2) : $urandom_range(3, 12));
        1: write_reg(REG_SRC_HEIGHT, ($urandom_range(0, 9) == 0) ?
                     $urandom_range(0, 2) : $urandom_range(3, 8));
        2: begin
          write_reg(REG_SRC_WIDTH, $urandom_range(3, 12));
          write_reg(REG_SRC_HEIGHT, $urandom_range(3, 8));
        end
        default: begin
          // unused index: frame continues where it stopped
          write_reg($urandom_range(0, 1) ? REG_RESERVED0 : REG_RESERVED1, $urandom());
        end
      endcase
      n = $urandom_range(4, 50);
      repeat (n) send(rand_pixel());
      random_sent += n;
      settle();
      pick = $urandom_range(0, 3);
    end

    // widest row setting and a clamped width above it, each only into the first row
    frame_phase(1024, 0, 40);
    frame_phase(2047, 1, 40);

    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
